// File: sv/c8ex_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c8ex_pkg;

   // operation codes as they arrive on the request channel
   typedef enum logic [5:0] {
      CMD_ORA = 6'd0,  CMD_AND = 6'd1,  CMD_EOR = 6'd2,  CMD_ADC = 6'd3,
      CMD_SBC = 6'd4,  CMD_CMP = 6'd5,  CMD_CPX = 6'd6,  CMD_CPY = 6'd7,
      CMD_LDA = 6'd8,  CMD_LDX = 6'd9,  CMD_LDY = 6'd10, CMD_BIT = 6'd11,
      CMD_ASL = 6'd12, CMD_LSR = 6'd13, CMD_ROL = 6'd14, CMD_ROR = 6'd15,
      CMD_INC = 6'd16, CMD_DEC = 6'd17, CMD_INX = 6'd18, CMD_INY = 6'd19,
      CMD_DEX = 6'd20, CMD_DEY = 6'd21, CMD_TAX = 6'd22, CMD_TAY = 6'd23,
      CMD_TXA = 6'd24, CMD_TYA = 6'd25, CMD_TSX = 6'd26, CMD_TXS = 6'd27,
      CMD_CLC = 6'd28, CMD_SEC = 6'd29, CMD_CLI = 6'd30, CMD_SEI = 6'd31,
      CMD_CLD = 6'd32, CMD_SED = 6'd33, CMD_CLV = 6'd34, CMD_STA = 6'd35,
      CMD_STX = 6'd36, CMD_STY = 6'd37, CMD_PHA = 6'd38, CMD_PHP = 6'd39,
      CMD_PLA = 6'd40, CMD_PLP = 6'd41
   } command_type;

   typedef enum logic [3:0] {
      ALU_OR, ALU_AND, ALU_EOR, ALU_ADD, ALU_CMP, ALU_PASS, ALU_INC, ALU_DEC,
      ALU_ASL, ALU_LSR, ALU_ROL, ALU_ROR, ALU_BIT
   } alu_op_type;

   typedef enum logic [2:0] {
      SRC_A, SRC_X, SRC_Y, SRC_S, SRC_STATUS, SRC_OPERAND
   } src_type;

   typedef enum logic [2:0] {
      DST_NONE, DST_A, DST_X, DST_Y, DST_S
   } dest_type;

   typedef enum logic [3:0] {
      FLG_NONE, FLG_CLC, FLG_SEC, FLG_CLI, FLG_SEI, FLG_CLD, FLG_SED, FLG_CLV,
      FLG_PLP
   } flag_op_type;

   typedef enum logic [1:0] {
      STK_NONE, STK_PUSH, STK_PULL
   } stack_op_type;

   typedef struct packed {
      logic [5:0] command;
      logic [7:0] operand_byte;
      logic       on_accumulator;
   } req_type;

   typedef struct packed {
      logic [7:0] write_data;
      logic       write_enable;
      logic       to_stack;
      logic [8:0] stack_address;
      logic [7:0] status_out;
      logic [7:0] accumulator_out;
   } rsp_type;

   // decoded micro-op handed from the front end to the execute side
   typedef struct packed {
      alu_op_type   alu_op;
      src_type      src;
      logic         invert_b;
      dest_type     dest;
      logic         write_mem;
      logic         upd_nz;
      logic         upd_c;
      logic         upd_v;
      flag_op_type  flag_op;
      stack_op_type stack_op;
      logic [7:0]   operand_byte;
   } uop_type;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] STATUS_RESET = 8'h34;
   localparam logic [7:0] SP_RESET     = 8'hfd;
   localparam logic [7:0] PLP_MASK     = 8'hef;
   localparam logic [7:0] PUSH_BITS    = 8'h30;
   localparam logic [7:0] FORCE_U      = 8'h20;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

endpackage

`default_nettype wire

// File: sv/c8ex_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module c8ex_decode (
   input  c8ex_pkg::req_type req,
   output c8ex_pkg::uop_type uop
);
   import c8ex_pkg::*;

   always_comb begin
      uop              = '0;
      uop.alu_op       = ALU_PASS;
      uop.src          = SRC_A;
      uop.dest         = DST_NONE;
      uop.flag_op      = FLG_NONE;
      uop.stack_op     = STK_NONE;
      uop.operand_byte = req.operand_byte;
      case (command_type'(req.command))
         CMD_ORA: begin uop.alu_op = ALU_OR;  uop.dest = DST_A; uop.upd_nz = 1'b1; end
         CMD_AND: begin uop.alu_op = ALU_AND; uop.dest = DST_A; uop.upd_nz = 1'b1; end
         CMD_EOR: begin uop.alu_op = ALU_EOR; uop.dest = DST_A; uop.upd_nz = 1'b1; end
         CMD_ADC, CMD_SBC: begin
            uop.alu_op   = ALU_ADD;
            uop.invert_b = (command_type'(req.command) == CMD_SBC);
            uop.dest     = DST_A;
            uop.upd_nz   = 1'b1;
            uop.upd_c    = 1'b1;
            uop.upd_v    = 1'b1;
         end
         CMD_CMP, CMD_CPX, CMD_CPY: begin
            uop.alu_op = ALU_CMP;
            uop.src    = (command_type'(req.command) == CMD_CPX) ? SRC_X :
                         (command_type'(req.command) == CMD_CPY) ? SRC_Y : SRC_A;
            uop.upd_nz = 1'b1;
            uop.upd_c  = 1'b1;
         end
         CMD_LDA: begin uop.src = SRC_OPERAND; uop.dest = DST_A; uop.upd_nz = 1'b1; end
         CMD_LDX: begin uop.src = SRC_OPERAND; uop.dest = DST_X; uop.upd_nz = 1'b1; end
         CMD_LDY: begin uop.src = SRC_OPERAND; uop.dest = DST_Y; uop.upd_nz = 1'b1; end
         CMD_BIT: begin uop.alu_op = ALU_BIT; uop.upd_nz = 1'b1; uop.upd_v = 1'b1; end
         CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
            case (command_type'(req.command))
               CMD_ASL: uop.alu_op = ALU_ASL;
               CMD_LSR: uop.alu_op = ALU_LSR;
               CMD_ROL: uop.alu_op = ALU_ROL;
               default: uop.alu_op = ALU_ROR;
            endcase
            uop.src       = req.on_accumulator ? SRC_A : SRC_OPERAND;
            uop.dest      = req.on_accumulator ? DST_A : DST_NONE;
            uop.write_mem = ~req.on_accumulator;
            uop.upd_nz    = 1'b1;
            uop.upd_c     = 1'b1;
         end
         CMD_INC: begin
            uop.alu_op = ALU_INC; uop.src = SRC_OPERAND;
            uop.write_mem = 1'b1; uop.upd_nz = 1'b1;
         end
         CMD_DEC: begin
            uop.alu_op = ALU_DEC; uop.src = SRC_OPERAND;
            uop.write_mem = 1'b1; uop.upd_nz = 1'b1;
         end
         CMD_INX: begin uop.alu_op = ALU_INC; uop.src = SRC_X; uop.dest = DST_X; uop.upd_nz = 1'b1; end
         CMD_INY: begin uop.alu_op = ALU_INC; uop.src = SRC_Y; uop.dest = DST_Y; uop.upd_nz = 1'b1; end
         CMD_DEX: begin uop.alu_op = ALU_DEC; uop.src = SRC_X; uop.dest = DST_X; uop.upd_nz = 1'b1; end
         CMD_DEY: begin uop.alu_op = ALU_DEC; uop.src = SRC_Y; uop.dest = DST_Y; uop.upd_nz = 1'b1; end
         CMD_TAX: begin uop.src = SRC_A; uop.dest = DST_X; uop.upd_nz = 1'b1; end
         CMD_TAY: begin uop.src = SRC_A; uop.dest = DST_Y; uop.upd_nz = 1'b1; end
         CMD_TXA: begin uop.src = SRC_X; uop.dest = DST_A; uop.upd_nz = 1'b1; end
         CMD_TYA: begin uop.src = SRC_Y; uop.dest = DST_A; uop.upd_nz = 1'b1; end
         CMD_TSX: begin uop.src = SRC_S; uop.dest = DST_X; uop.upd_nz = 1'b1; end
         CMD_TXS: begin uop.src = SRC_X; uop.dest = DST_S; end
         CMD_CLC: uop.flag_op = FLG_CLC;
         CMD_SEC: uop.flag_op = FLG_SEC;
         CMD_CLI: uop.flag_op = FLG_CLI;
         CMD_SEI: uop.flag_op = FLG_SEI;
         CMD_CLD: uop.flag_op = FLG_CLD;
         CMD_SED: uop.flag_op = FLG_SED;
         CMD_CLV: uop.flag_op = FLG_CLV;
         CMD_STA: begin uop.src = SRC_A; uop.write_mem = 1'b1; end
         CMD_STX: begin uop.src = SRC_X; uop.write_mem = 1'b1; end
         CMD_STY: begin uop.src = SRC_Y; uop.write_mem = 1'b1; end
         CMD_PHA: begin uop.src = SRC_A;      uop.write_mem = 1'b1; uop.stack_op = STK_PUSH; end
         CMD_PHP: begin uop.src = SRC_STATUS; uop.write_mem = 1'b1; uop.stack_op = STK_PUSH; end
         CMD_PLA: begin
            uop.src = SRC_OPERAND; uop.dest = DST_A; uop.upd_nz = 1'b1;
            uop.stack_op = STK_PULL;
         end
         CMD_PLP: begin uop.flag_op = FLG_PLP; uop.stack_op = STK_PULL; end
         default: ; // unassigned codes: no effect
      endcase
   end

endmodule

`default_nettype wire

// File: sv/c8ex_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module c8ex_queue #(
   parameter int DEPTH = c8ex_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  c8ex_pkg::uop_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output c8ex_pkg::uop_type pop_data
);
   import c8ex_pkg::*;

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   uop_type         entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push, pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: sv/c8ex_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module c8ex_exec (
   input  logic              clock,
   input  logic              reset,
   input  logic              uop_valid,
   output logic              uop_ready,
   input  c8ex_pkg::uop_type uop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output c8ex_pkg::rsp_type rsp_data
);
   import c8ex_pkg::*;

   logic [7:0] acc_ff, acc_in;
   logic [7:0] x_ff, x_in;
   logic [7:0] y_ff, y_in;
   logic [7:0] sp_ff, sp_in;
   logic [7:0] status_ff, status_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       fire;

   assign uop_ready = ~rsp_valid_ff | rsp_ready;
   assign fire      = uop_valid & uop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [7:0] a_val;
      logic [7:0] b_val;
      logic [8:0] sum;
      logic [7:0] res;
      logic       c_val;
      logic       v_val;
      logic       n_val;
      logic       z_val;
      logic       cin;

      cin = status_ff[FLAG_C];
      case (uop.src)
         SRC_A:      a_val = acc_ff;
         SRC_X:      a_val = x_ff;
         SRC_Y:      a_val = y_ff;
         SRC_S:      a_val = sp_ff;
         SRC_STATUS: a_val = status_ff | PUSH_BITS;
         default:    a_val = uop.operand_byte;
      endcase
      b_val = uop.invert_b ? ~uop.operand_byte : uop.operand_byte;

      sum   = '0;
      res   = a_val;
      c_val = cin;
      v_val = status_ff[FLAG_V];
      case (uop.alu_op)
         ALU_OR:  res = a_val | b_val;
         ALU_AND: res = a_val & b_val;
         ALU_EOR: res = a_val ^ b_val;
         ALU_ADD: begin
            sum   = {1'b0, a_val} + {1'b0, b_val} + {8'b0, cin};
            res   = sum[7:0];
            c_val = sum[8];
            v_val = ~(a_val[7] ^ b_val[7]) & (a_val[7] ^ res[7]);
         end
         ALU_CMP: begin
            // reg - op as reg + ~op + 1; carry out means reg >= op
            sum   = {1'b0, a_val} + {1'b0, ~b_val} + 9'd1;
            res   = sum[7:0];
            c_val = sum[8];
         end
         ALU_INC: res = a_val + 8'd1;
         ALU_DEC: res = a_val - 8'd1;
         ALU_ASL: begin res = {a_val[6:0], 1'b0}; c_val = a_val[7]; end
         ALU_LSR: begin res = {1'b0, a_val[7:1]}; c_val = a_val[0]; end
         ALU_ROL: begin res = {a_val[6:0], cin};  c_val = a_val[7]; end
         ALU_ROR: begin res = {cin, a_val[7:1]};  c_val = a_val[0]; end
         ALU_BIT: begin
            res   = a_val & b_val;
            v_val = b_val[6];
         end
         default: res = a_val;
      endcase

      z_val = (res == 8'd0);
      n_val = (uop.alu_op == ALU_BIT) ? b_val[7] : res[7];

      status_in = status_ff;
      if (uop.upd_nz) begin
         status_in[FLAG_N] = n_val;
         status_in[FLAG_Z] = z_val;
      end
      if (uop.upd_c) status_in[FLAG_C] = c_val;
      if (uop.upd_v) status_in[FLAG_V] = v_val;
      case (uop.flag_op)
         FLG_CLC: status_in[FLAG_C] = 1'b0;
         FLG_SEC: status_in[FLAG_C] = 1'b1;
         FLG_CLI: status_in[FLAG_I] = 1'b0;
         FLG_SEI: status_in[FLAG_I] = 1'b1;
         FLG_CLD: status_in[FLAG_D] = 1'b0;
         FLG_SED: status_in[FLAG_D] = 1'b1;
         FLG_CLV: status_in[FLAG_V] = 1'b0;
         FLG_PLP: status_in = (uop.operand_byte & PLP_MASK)
                              | (status_ff & ~PLP_MASK) | FORCE_U;
         default: ;
      endcase

      acc_in = acc_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      sp_in  = sp_ff;
      case (uop.dest)
         DST_A:   acc_in = res;
         DST_X:   x_in   = res;
         DST_Y:   y_in   = res;
         DST_S:   sp_in  = res;
         default: ;
      endcase

      rsp_in = '0;
      case (uop.stack_op)
         STK_PUSH: begin
            sp_in                = sp_ff - 8'd1;
            rsp_in.to_stack      = 1'b1;
            rsp_in.stack_address = {1'b1, sp_ff};
         end
         STK_PULL: begin
            sp_in                = sp_ff + 8'd1;
            rsp_in.to_stack      = 1'b1;
            rsp_in.stack_address = {1'b1, sp_in};
         end
         default: rsp_in.stack_address = {1'b1, sp_in};
      endcase
      rsp_in.write_enable    = uop.write_mem;
      rsp_in.write_data      = uop.write_mem ? res : 8'd0;
      rsp_in.status_out      = status_in;
      rsp_in.accumulator_out = acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         sp_ff        <= SP_RESET;
         status_ff    <= STATUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            acc_ff    <= acc_in;
            x_ff      <= x_in;
            y_ff      <= y_in;
            sp_ff     <= sp_in;
            status_ff <= status_in;
         end
         if (uop_ready) begin
            rsp_valid_ff <= uop_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/cpu8_execute_alu_flags.sv
`timescale 1ns / 1ps
`default_nettype none

// Binary-mode execute unit of an 8-bit 6502-style core. Holds A, X, Y, the
// stack pointer and the status register, and gives one response per request:
// write-back/store/push byte, stack address and the updated status and
// accumulator. Sustained rate is one request per clock while the response
// side is not stalled; a request passes through the decoded-op queue and then
// the ALU into the output register before its response is valid. The queue
// holds QUEUE_DEPTH decoded ops, so req_ready drops only once the response
// side has been stalled long enough to fill it. No decimal mode.
module cpu8_execute_alu_flags #(
   parameter int QUEUE_DEPTH = c8ex_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  c8ex_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output c8ex_pkg::rsp_type rsp_data
);
   import c8ex_pkg::*;

   uop_type dec_uop;    // decoded request, front end
   uop_type exe_uop;    // queue head, execute side
   logic    exe_valid;
   logic    exe_ready;

   // front end: classify the request into a micro-op
   c8ex_decode u_decode (
      .req (req_data),
      .uop (dec_uop)
   );

   // decouples decode from execute; each side stalls on its own
   c8ex_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (dec_uop),
      .pop_valid  (exe_valid),
      .pop_ready  (exe_ready),
      .pop_data   (exe_uop)
   );

   // back end: register file, ALU, flags and registered response
   c8ex_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .uop_valid (exe_valid),
      .uop_ready (exe_ready),
      .uop       (exe_uop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a response without a write carries a zero byte
   a_no_write_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_enable |-> rsp_data.write_data == 8'd0)
      else $error("write_data not zero on a response without write");

   // B and unused status bits stay set from reset onwards
   a_status_fixed_bits : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status_out[5] && rsp_data.status_out[4])
      else $error("status bits 5/4 lost");

   // a new response only comes from a queued op
   a_rsp_from_queue : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(exe_valid))
      else $error("response raised without a queued op");

endmodule

`default_nettype wire
